// ----- hw/rtl/nfcs_pkg.sv -----
// Shared types, constants and beat expansion for the NAND flash command sequencer.
// Used by nfcs_front, nfcs_queue, nfcs_back and the top level.
package nfcs_pkg;

  localparam int PAGE_BYTES      = 2048;
  localparam int PAGES_PER_BLOCK = 64;
  localparam int BLOCK_COUNT     = 2048;
  localparam int ID_BYTES        = 5;

  localparam int ROW_W      = 17;
  localparam int COUNT_W    = 12;
  localparam int TIMEOUT_W  = 24;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CMD_CHIP_RST    = 8'hFF;
  localparam logic [7:0] CMD_READ_ID     = 8'h90;
  localparam logic [7:0] CMD_ERASE_SETUP = 8'h60;
  localparam logic [7:0] CMD_ERASE_GO    = 8'hD0;
  localparam logic [7:0] CMD_PROG1       = 8'h80;
  localparam logic [7:0] CMD_PROG2       = 8'h10;
  localparam logic [7:0] CMD_READ_SETUP  = 8'h00;
  localparam logic [7:0] CMD_READ2       = 8'h30;
  localparam logic [7:0] CMD_STATUS      = 8'h70;
  localparam logic [7:0] COL_SPARE_HI    = 8'h08;
  localparam logic [7:0] MARK_GOOD       = 8'hFF;

  typedef enum logic [2:0] {
    K_CMD      = 3'd0,
    K_ADDR     = 3'd1,
    K_WRITE    = 3'd2,
    K_STROBE   = 3'd3,
    K_SELECT   = 3'd4,
    K_DESELECT = 3'd5,
    K_HOST     = 3'd6,
    K_DONE     = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    RC_OK   = 2'd0,
    RC_FAIL = 2'd1,
    RC_BAD  = 2'd2
  } rcode_t;

  // Bursts the back end expands into bus beats
  typedef enum logic [3:0] {
    SQ_RESET       = 4'd0,
    SQ_ID          = 4'd1,
    SQ_ERASE       = 4'd2,
    SQ_PROG        = 4'd3,
    SQ_READ        = 4'd4,
    SQ_CHECK       = 4'd5,
    SQ_CHECK2      = 4'd6,
    SQ_STATUS      = 4'd7,
    SQ_STROBE      = 4'd8,
    SQ_FINISH      = 4'd9,
    SQ_HOST_STROBE = 4'd10,
    SQ_HOST_FINISH = 4'd11,
    SQ_WRITE       = 4'd12,
    SQ_WRITE_LAST  = 4'd13
  } seq_t;

  typedef struct packed {
    seq_t             seq;
    logic [ROW_W-1:0] row;
    logic [7:0]       data;
    rcode_t           code;
  } job_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] bus;
    logic [7:0] host;
    rcode_t     code;
    logic       last;
  } beat_t;

  function automatic beat_t mk_beat(kind_t k, logic [7:0] v);
    beat_t b;
    b = '0;
    b.kind = k;
    b.bus  = v;
    return b;
  endfunction

  function automatic logic [7:0] row_byte(logic [ROW_W-1:0] row, logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = row[7:0];
      2'd1:    r = row[15:8];
      default: r = {7'b0, row[16]};
    endcase
    return r;
  endfunction

  function automatic logic [3:0] seq_last_step(seq_t s);
    logic [3:0] n;
    case (s)
      SQ_RESET:       n = 4'd1;
      SQ_ID:          n = 4'd3;
      SQ_ERASE:       n = 4'd5;
      SQ_PROG:        n = 4'd6;
      SQ_READ:        n = 4'd7;
      SQ_CHECK:       n = 4'd7;
      SQ_CHECK2:      n = 4'd8;
      SQ_STATUS:      n = 4'd1;
      SQ_HOST_STROBE: n = 4'd1;
      SQ_HOST_FINISH: n = 4'd2;
      SQ_FINISH:      n = 4'd1;
      SQ_WRITE_LAST:  n = 4'd1;
      default:        n = 4'd0;
    endcase
    return n;
  endfunction

  // Page read address phase: select, 00, col lo, col hi, three row bytes, 30
  function automatic beat_t read_beat(logic [ROW_W-1:0] row, logic [7:0] col_hi,
                                      logic [3:0] s);
    beat_t b;
    case (s)
      4'd0:    b = mk_beat(K_SELECT, 8'h00);
      4'd1:    b = mk_beat(K_CMD, CMD_READ_SETUP);
      4'd2:    b = mk_beat(K_ADDR, 8'h00);
      4'd3:    b = mk_beat(K_ADDR, col_hi);
      4'd4:    b = mk_beat(K_ADDR, row_byte(row, 2'd0));
      4'd5:    b = mk_beat(K_ADDR, row_byte(row, 2'd1));
      4'd6:    b = mk_beat(K_ADDR, row_byte(row, 2'd2));
      default: b = mk_beat(K_CMD, CMD_READ2);
    endcase
    return b;
  endfunction

  function automatic beat_t job_beat(job_t j, logic [3:0] step);
    beat_t b;
    b = '0;
    case (j.seq)
      SQ_RESET:
        b = (step == 4'd0) ? mk_beat(K_SELECT, 8'h00) : mk_beat(K_CMD, CMD_CHIP_RST);
      SQ_ID: begin
        case (step)
          4'd0:    b = mk_beat(K_SELECT, 8'h00);
          4'd1:    b = mk_beat(K_CMD, CMD_READ_ID);
          4'd2:    b = mk_beat(K_ADDR, 8'h00);
          default: b = mk_beat(K_STROBE, 8'h00);
        endcase
      end
      SQ_ERASE: begin
        case (step)
          4'd0:    b = mk_beat(K_SELECT, 8'h00);
          4'd1:    b = mk_beat(K_CMD, CMD_ERASE_SETUP);
          4'd2:    b = mk_beat(K_ADDR, row_byte(j.row, 2'd0));
          4'd3:    b = mk_beat(K_ADDR, row_byte(j.row, 2'd1));
          4'd4:    b = mk_beat(K_ADDR, row_byte(j.row, 2'd2));
          default: b = mk_beat(K_CMD, CMD_ERASE_GO);
        endcase
      end
      SQ_PROG: begin
        case (step)
          4'd0:    b = mk_beat(K_SELECT, 8'h00);
          4'd1:    b = mk_beat(K_CMD, CMD_PROG1);
          4'd2:    b = mk_beat(K_ADDR, 8'h00);
          4'd3:    b = mk_beat(K_ADDR, 8'h00);
          4'd4:    b = mk_beat(K_ADDR, row_byte(j.row, 2'd0));
          4'd5:    b = mk_beat(K_ADDR, row_byte(j.row, 2'd1));
          default: b = mk_beat(K_ADDR, row_byte(j.row, 2'd2));
        endcase
      end
      SQ_READ:  b = read_beat(j.row, 8'h00, step);
      SQ_CHECK: b = read_beat(j.row, COL_SPARE_HI, step);
      SQ_CHECK2: begin
        // drop the chip select of the first mark read before the second one
        if (step == 4'd0) begin
          b = mk_beat(K_DESELECT, 8'h00);
        end else begin
          b = read_beat(j.row, COL_SPARE_HI, step - 4'd1);
        end
      end
      SQ_STATUS:
        b = (step == 4'd0) ? mk_beat(K_CMD, CMD_STATUS) : mk_beat(K_STROBE, 8'h00);
      SQ_STROBE: b = mk_beat(K_STROBE, 8'h00);
      SQ_HOST_STROBE, SQ_HOST_FINISH: begin
        case (step)
          4'd0: begin
            b = mk_beat(K_HOST, 8'h00);
            b.host = j.data;
          end
          4'd1: begin
            if (j.seq == SQ_HOST_STROBE) begin
              b = mk_beat(K_STROBE, 8'h00);
            end else begin
              b = mk_beat(K_DESELECT, 8'h00);
            end
          end
          default: begin
            b = mk_beat(K_DONE, 8'h00);
            b.code = j.code;
          end
        endcase
      end
      SQ_FINISH: begin
        if (step == 4'd0) begin
          b = mk_beat(K_DESELECT, 8'h00);
        end else begin
          b = mk_beat(K_DONE, 8'h00);
          b.code = j.code;
        end
      end
      SQ_WRITE, SQ_WRITE_LAST:
        b = (step == 4'd0) ? mk_beat(K_WRITE, j.data) : mk_beat(K_CMD, CMD_PROG2);
      default: b = '0;
    endcase
    b.last = (step == seq_last_step(j.seq));
    return b;
  endfunction

endpackage

// ----- hw/rtl/nfcs_front.sv -----
// Front end: accepts request items, tracks the operation phase and pushes bursts.
// Depends on nfcs_pkg.
module nfcs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [nfcs_pkg::TIMEOUT_W-1:0] timeout,
  input  logic                           acc,
  input  logic [2:0]                     req_type,
  input  logic [2:0]                     op,
  input  logic [10:0]                    blk,
  input  logic [5:0]                     page,
  input  logic [7:0]                     data_byte,
  output logic                           push,
  output nfcs_pkg::job_t                 job
);
  import nfcs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_ID_READ, PH_PROG_DATA, PH_STATUS_READ, PH_PAGE_READ, PH_MARK_READ
  } phase_t;

  typedef enum logic [2:0] {
    REQ_START = 3'd0, REQ_READY = 3'd1, REQ_TICK = 3'd2, REQ_HOST_WR = 3'd3, REQ_FLASH_RD = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    OP_RESET = 3'd0, OP_READ_ID = 3'd1, OP_ERASE = 3'd2, OP_PROGRAM = 3'd3,
    OP_READ = 3'd4, OP_CHECK = 3'd5
  } op_t;

  phase_t               phase_r, phase_nxt;
  logic [2:0]           cur_op_r, cur_op_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [TIMEOUT_W-1:0] wait_r, wait_nxt;
  logic                 check_r, check_nxt;

  logic [TIMEOUT_W-1:0] wait_inc;
  logic [COUNT_W:0]     count_inc;
  logic [ROW_W-1:0]     start_row;
  logic [5:0]           start_page;
  logic                 go;

  assign wait_inc   = wait_r + 1'b1;
  assign count_inc  = {1'b0, count_r} + 1'b1;
  assign start_page = (op == OP_ERASE || op == OP_CHECK) ? 6'd0
                      : 6'(32'(page) % PAGES_PER_BLOCK);
  assign start_row  = ROW_W'((32'(blk) % BLOCK_COUNT) * PAGES_PER_BLOCK + 32'(start_page));

  // ready seen, or the tick count has run out
  assign go = acc && (req_type == REQ_READY ||
                      (req_type == REQ_TICK && wait_inc >= timeout));

  always_comb begin
    phase_nxt  = phase_r;
    cur_op_nxt = cur_op_r;
    row_nxt    = row_r;
    count_nxt  = count_r;
    wait_nxt   = wait_r;
    check_nxt  = check_r;
    push       = 1'b0;
    job        = '0;
    job.data   = data_byte;
    job.code   = RC_OK;
    case (phase_r)
      PH_IDLE: begin
        if (acc && req_type == REQ_START && op <= OP_CHECK) begin
          cur_op_nxt = op;
          count_nxt  = '0;
          check_nxt  = 1'b0;
          row_nxt    = start_row;
          wait_nxt   = '0;
          push       = 1'b1;
          phase_nxt  = PH_WAIT;
          case (op)
            OP_RESET:   job.seq = SQ_RESET;
            OP_READ_ID: begin
              job.seq   = SQ_ID;
              phase_nxt = PH_ID_READ;
              wait_nxt  = wait_r;
            end
            OP_ERASE:   job.seq = SQ_ERASE;
            OP_PROGRAM: begin
              job.seq   = SQ_PROG;
              phase_nxt = PH_PROG_DATA;
              wait_nxt  = wait_r;
            end
            OP_READ:    job.seq = SQ_READ;
            default:    job.seq = SQ_CHECK;
          endcase
        end
      end
      PH_WAIT: begin
        if (acc && req_type == REQ_TICK) begin
          wait_nxt = wait_inc;
        end
        if (go) begin
          push = 1'b1;
          case (cur_op_r)
            OP_RESET: begin
              job.seq   = SQ_FINISH;
              phase_nxt = PH_IDLE;
            end
            OP_ERASE, OP_PROGRAM: begin
              job.seq   = SQ_STATUS;
              phase_nxt = PH_STATUS_READ;
            end
            OP_READ: begin
              job.seq   = SQ_STROBE;
              count_nxt = '0;
              phase_nxt = PH_PAGE_READ;
            end
            default: begin
              job.seq   = SQ_STROBE;
              phase_nxt = PH_MARK_READ;
            end
          endcase
        end
      end
      PH_ID_READ: begin
        if (acc && req_type == REQ_FLASH_RD) begin
          push = 1'b1;
          if (count_inc >= (COUNT_W+1)'(ID_BYTES)) begin
            job.seq   = SQ_HOST_FINISH;
            phase_nxt = PH_IDLE;
          end else begin
            job.seq   = SQ_HOST_STROBE;
            count_nxt = count_inc[COUNT_W-1:0];
          end
        end
      end
      PH_PROG_DATA: begin
        if (acc && req_type == REQ_HOST_WR) begin
          push = 1'b1;
          if (count_inc >= (COUNT_W+1)'(PAGE_BYTES)) begin
            job.seq   = SQ_WRITE_LAST;
            wait_nxt  = '0;
            phase_nxt = PH_WAIT;
          end else begin
            job.seq   = SQ_WRITE;
            count_nxt = count_inc[COUNT_W-1:0];
          end
        end
      end
      PH_STATUS_READ: begin
        if (acc && req_type == REQ_FLASH_RD) begin
          push      = 1'b1;
          job.seq   = SQ_FINISH;
          job.code  = data_byte[0] ? RC_FAIL : RC_OK;
          phase_nxt = PH_IDLE;
        end
      end
      PH_PAGE_READ: begin
        if (acc && req_type == REQ_FLASH_RD) begin
          push = 1'b1;
          if (count_inc >= (COUNT_W+1)'(PAGE_BYTES)) begin
            job.seq   = SQ_HOST_FINISH;
            phase_nxt = PH_IDLE;
          end else begin
            job.seq   = SQ_HOST_STROBE;
            count_nxt = count_inc[COUNT_W-1:0];
          end
        end
      end
      PH_MARK_READ: begin
        if (acc && req_type == REQ_FLASH_RD) begin
          push = 1'b1;
          if (data_byte != MARK_GOOD) begin
            job.seq   = SQ_FINISH;
            job.code  = RC_BAD;
            phase_nxt = PH_IDLE;
          end else if (!check_r) begin
            // advance to the next page and read its mark
            job.seq   = SQ_CHECK2;
            check_nxt = 1'b1;
            row_nxt   = row_r + 1'b1;
            wait_nxt  = '0;
            phase_nxt = PH_WAIT;
          end else begin
            job.seq   = SQ_FINISH;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
    job.row = row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cur_op_r <= '0;
      row_r    <= '0;
      count_r  <= '0;
      wait_r   <= '0;
      check_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cur_op_r <= cur_op_nxt;
      row_r    <= row_nxt;
      count_r  <= count_nxt;
      wait_r   <= wait_nxt;
      check_r  <= check_nxt;
    end
  end

endmodule

// ----- hw/rtl/nfcs_queue.sv -----
// Short burst queue between the front and back ends.
// Depends on nfcs_pkg.
module nfcs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nfcs_pkg::job_t push_job,
  input  logic           pop,
  output nfcs_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import nfcs_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/nfcs_back.sv -----
// Back end: expands queued bursts into bus beats in beat_r, one per cycle unless stalled.
// Depends on nfcs_pkg.
module nfcs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  nfcs_pkg::job_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output nfcs_pkg::beat_t out_beat
);
  import nfcs_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  beat_t      beat_r, beat;
  logic       load;

  assign beat      = job_beat(head, step_r);
  assign load      = !empty && (!valid_r || out_ready);
  assign pop       = load && beat.last;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = beat.last ? 4'd0 : step_r + 4'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/nand_flash_command_sequencer.sv -----
// Top level of the NAND flash command sequencer: register port, front end, queue, back end.
// Depends on nfcs_pkg, nfcs_front, nfcs_queue and nfcs_back.
//
// Usage:
//   Request items enter on in_* (valid/ready). A start item picks an operation;
//   ready, wait-tick, host-write and flash-read items drive it along. Items that
//   do not fit the current phase are taken and dropped with no beats.
//   Bus beats leave on out_* (valid/ready), one per cycle; out_last marks the
//   final beat caused by an item. An item expands into at most nine beats (a good
//   first bad-block mark), a start item into at most eight.
//   The front end takes one item per cycle while in_ready is high and pushes at
//   most one burst into a four-entry queue; the back end turns each burst into
//   beats at one per cycle while out_ready is high. Page program data thus streams
//   at one item per cycle; page read and ID bytes cost two beats each, so stream slower.
//   The first beat of an item passes through the queue and then the back end's
//   output register before out_valid shows it.
//   in_ready falls only while the queue is full: when out_ready is held low, or
//   when multi-beat bursts arrive faster than the back end drains them.
//   ready_timeout is written over the APB port at address 0; write it only idle.
//   Reset (rst_n low, synchronous) returns to idle, empties the queue and
//   restores ready_timeout to 1000000.
module nand_flash_command_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_op,
  input  logic [10:0] in_block,
  input  logic [5:0]  in_page,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_cycle_kind,
  output logic [7:0]  out_bus_byte,
  output logic [7:0]  out_host_byte,
  output logic [1:0]  out_result_code,
  output logic        out_last
);
  import nfcs_pkg::*;

  localparam logic REG_TIMEOUT = 1'b0;

  logic [TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic                 acc, push, pop, empty, full;
  job_t                 push_job, head;
  beat_t                beat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {8'h00, timeout_r} : 32'h0;

  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT) begin
      timeout_nxt = pwdata[TIMEOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  nfcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .timeout   (timeout_r),
    .acc       (acc),
    .req_type  (in_req_type),
    .op        (in_op),
    .blk       (in_block),
    .page      (in_page),
    .data_byte (in_data_byte),
    .push      (push),
    .job       (push_job)
  );

  nfcs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  nfcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (beat)
  );

  assign out_cycle_kind  = beat.kind;
  assign out_bus_byte    = beat.bus;
  assign out_host_byte   = beat.host;
  assign out_result_code = beat.code;
  assign out_last        = beat.last;

endmodule
